// ===== design/spme_pkg.sv =====
// Shared types and constants for the shortest-path matrix engine.
package spme_pkg;
	localparam int MAX_VERTICES = 64;
	localparam int WEIGHT_BITS = 16;

	localparam int DIST_BITS = 22;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_RUN  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDGE_A,
		ST_EDGE_B,
		ST_INIT,
		ST_SCAN,
		ST_SCAN_END,
		ST_RELAX,
		ST_RELAX_END,
		ST_EMIT,
		ST_ERR
	} state_t;
endpackage

// ===== design/spme_wmem.sv =====
// Weight matrix memory: one write port, one registered read port.
module spme_wmem #(
	parameter int ADDR_BITS = 12,
	parameter int DATA_BITS = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [DATA_BITS-1:0] wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [DATA_BITS-1:0] rdata
);
	logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

	// write and read the array
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/shortest_path_matrix_engine_top.sv =====
// Top level of the shortest-path matrix engine: control and vertex state.
//
//  channel | signals                                         | handshake
//  input   | kind first_vertex second_vertex edge_weight     | start && !busy
//  config  | cfg_data (vertex_count)                         | cfg_valid && cfg_ready
//  result  | status vertex distance reachable parent_vertex  | strobe, one cycle
//          | has_parent last                                 |
//
// Sequence: after reset a clearing pass zeroes all MAX_VERTICES*MAX_VERTICES words of
// the weight memory; busy stays high meanwhile. An edge item is busy for two memory
// writes and its result follows in the next cycle; a rejected item is busy only in
// the error state. A run scans and relaxes for each of n-1 steps (no relax pass for
// a step whose picked vertex is unreached) and then emits; its duration is set by the
// single read port of each memory (one row word and one vertex word per cycle) and the
// sequential minimum scan. The receiver cannot stall; results leave one per cycle.
module shortest_path_matrix_engine_top
	import spme_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [5:0]  first_vertex,
	input  logic [5:0]  second_vertex,
	input  logic [15:0] edge_weight,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	output logic        strobe,
	output logic        status,
	output logic [5:0]  vertex,
	output logic [21:0] distance,
	output logic        reachable,
	output logic [5:0]  parent_vertex,
	output logic        has_parent,
	output logic        last
);
	localparam int VB = $clog2(MAX_VERTICES);
	localparam int CB = VB + 1;
	localparam int AB = 2 * VB;
	localparam int VW = VB + DIST_BITS;

	// configuration register
	logic [6:0] vcount_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 7'(MAX_VERTICES);
		end else if (cfg_valid && cfg_ready) begin
			vcount_q <= cfg_data;
		end
	end
	assign cfg_ready = 1'b1;

	// effective vertex count
	logic [CB-1:0] n;
	always_comb begin
		if (vcount_q == 7'd0) begin
			n = CB'(1);
		end else if ({25'd0, vcount_q} > 32'(MAX_VERTICES)) begin
			n = CB'(MAX_VERTICES);
		end else begin
			n = CB'(vcount_q);
		end
	end

	// per-vertex flags
	logic [MAX_VERTICES-1:0] reach_q, hasp_q, settled_q;

	state_t state_q, state_d;
	logic [AB:0]  clr_q;
	logic         clr_done;
	logic [CB-1:0] i_q;   // scan / relax / emit index
	logic [CB-1:0] iter_q;
	logic [VB-1:0] p_q, best_idx_q, src_q, a_q, b_q;
	logic [DIST_BITS:0] best_q; // bit DIST_BITS set means unreached
	logic [DIST_BITS-1:0] dp_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [VB-1:0] j_s1;
	logic          jv_s1;
	logic          sv_s1;

	assign clr_done = clr_q[AB];

	// weight memory
	logic               we;
	logic [AB-1:0]      waddr, raddr;
	logic [WEIGHT_BITS-1:0] wdata, rdata;
	spme_wmem #(.ADDR_BITS(AB), .DATA_BITS(WEIGHT_BITS)) u_wmem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [VB-1:0] iv;
	assign iv = i_q[VB-1:0];
	assign raddr = {p_q, iv};

	always_comb begin
		we = 1'b0;
		waddr = {a_q, b_q};
		wdata = w_q;
		if (!clr_done) begin
			we = 1'b1;
			waddr = clr_q[AB-1:0];
			wdata = '0;
		end else if (state_q == ST_EDGE_A) begin
			we = 1'b1;
		end else if (state_q == ST_EDGE_B) begin
			we = 1'b1;
			waddr = {b_q, a_q};
		end
	end

	// vertex memory: parent index over distance, read at the scan/relax/emit index
	logic [VW-1:0]        vmem [MAX_VERTICES];
	logic [VW-1:0]        vrd;
	logic                 vwe;
	logic [VB-1:0]        vwaddr;
	logic [VW-1:0]        vwdata;
	logic [DIST_BITS-1:0] vrd_dist;
	assign vrd_dist = vrd[DIST_BITS-1:0];

	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[vwaddr] <= vwdata;
		end
		vrd <= vmem[iv];
	end

	logic accept;
	assign busy = (state_q != ST_IDLE) || !clr_done;
	assign accept = start && !busy;

	logic a_bad, b_bad;
	assign a_bad = ({1'b0, first_vertex} >= 7'(n)) || (32'(first_vertex) >= MAX_VERTICES);
	assign b_bad = ({1'b0, second_vertex} >= 7'(n)) || (32'(second_vertex) >= MAX_VERTICES);

	// scan compare on the registered vertex word read in the previous cycle
	logic [DIST_BITS:0] dcur, pick_d;
	logic               scan_hit;
	logic [VB-1:0]      pick_idx;
	assign dcur = reach_q[j_s1] ? {1'b0, vrd_dist} : {1'b1, {DIST_BITS{1'b0}}};
	assign scan_hit = sv_s1 && !settled_q[j_s1] && (dcur <= best_q);
	assign pick_idx = scan_hit ? j_s1 : best_idx_q;
	assign pick_d = scan_hit ? dcur : best_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (kind == KIND_EDGE) begin
						state_d = (a_bad || b_bad) ? ST_ERR : ST_EDGE_A;
					end else begin
						state_d = a_bad ? ST_ERR : ST_INIT;
					end
				end
			end
			ST_EDGE_A:    state_d = ST_EDGE_B;
			ST_EDGE_B:    state_d = ST_IDLE;
			ST_INIT:      state_d = (n == CB'(1)) ? ST_EMIT : ST_SCAN;
			ST_SCAN:      state_d = (i_q == n - CB'(1)) ? ST_SCAN_END : ST_SCAN;
			ST_SCAN_END:  state_d = reach_q[pick_idx] ? ST_RELAX :
				((iter_q == n - CB'(2)) ? ST_EMIT : ST_SCAN);
			ST_RELAX:     state_d = (i_q == n - CB'(1)) ? ST_RELAX_END : ST_RELAX;
			ST_RELAX_END: state_d = (iter_q == n - CB'(2)) ? ST_EMIT : ST_SCAN;
			ST_EMIT:      state_d = (i_q == n - CB'(1)) ? ST_IDLE : ST_EMIT;
			ST_ERR:       state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_done) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// relax candidate from the registered row word
	logic [DIST_BITS:0] cand_full;
	logic [DIST_BITS-1:0] cand;
	logic relax_upd;
	assign cand_full = {1'b0, dp_q} + (DIST_BITS+1)'(rdata);
	assign cand = cand_full[DIST_BITS] ? DIST_MAX : cand_full[DIST_BITS-1:0];
	assign relax_upd = jv_s1 && !settled_q[j_s1] && (rdata != '0) &&
		(!reach_q[j_s1] || cand < vrd_dist);

	// vertex memory write: source seed on init, improved path on relax
	always_comb begin
		vwe = 1'b0;
		vwaddr = j_s1;
		vwdata = {p_q, cand};
		if (state_q == ST_INIT) begin
			vwe = 1'b1;
			vwaddr = src_q;
			vwdata = '0;
		end else if (relax_upd) begin
			vwe = 1'b1;
		end
	end

	// datapath and vertex flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			iter_q <= '0;
			reach_q <= '0;
			hasp_q <= '0;
			settled_q <= '0;
			jv_s1 <= 1'b0;
			sv_s1 <= 1'b0;
			j_s1 <= '0;
			a_q <= '0;
			b_q <= '0;
			src_q <= '0;
			w_q <= '0;
			p_q <= '0;
			best_idx_q <= '0;
			best_q <= '1;
			dp_q <= '0;
		end else begin
			jv_s1 <= 1'b0;
			sv_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					a_q <= first_vertex[VB-1:0];
					b_q <= second_vertex[VB-1:0];
					src_q <= first_vertex[VB-1:0];
					w_q <= edge_weight[WEIGHT_BITS-1:0];
					i_q <= '0;
					iter_q <= '0;
				end
				ST_INIT: begin
					reach_q <= MAX_VERTICES'(1) << src_q;
					hasp_q <= '0;
					settled_q <= '0;
					i_q <= '0;
					best_q <= '1;
					best_idx_q <= '0;
				end
				ST_SCAN: begin
					// read issued for i_q, compared next cycle
					if (scan_hit) begin
						best_q <= dcur;
						best_idx_q <= j_s1;
					end
					j_s1 <= iv;
					sv_s1 <= 1'b1;
					i_q <= (i_q == n - CB'(1)) ? '0 : i_q + 1'b1;
				end
				ST_SCAN_END: begin
					settled_q[pick_idx] <= 1'b1;
					p_q <= pick_idx;
					dp_q <= pick_d[DIST_BITS-1:0];
					i_q <= '0;
					best_q <= '1;
					best_idx_q <= '0;
					if (!reach_q[pick_idx]) iter_q <= iter_q + 1'b1;
				end
				ST_RELAX, ST_RELAX_END: begin
					// read issued for i_q, evaluated next cycle
					if (state_q == ST_RELAX) begin
						j_s1 <= iv;
						jv_s1 <= 1'b1;
						i_q <= (i_q == n - CB'(1)) ? '0 : i_q + 1'b1;
					end else begin
						iter_q <= iter_q + 1'b1;
						i_q <= '0;
					end
				end
				ST_EMIT: begin
					i_q <= i_q + 1'b1;
				end
				default: ;
			endcase
			if (relax_upd) begin
				reach_q[j_s1] <= 1'b1;
				hasp_q[j_s1] <= 1'b1;
			end
		end
	end

	// result outputs; distance and parent come from the vertex word read in emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
			last <= 1'b0;
			status <= 1'b0;
			vertex <= '0;
			reachable <= 1'b0;
			has_parent <= 1'b0;
		end else begin
			strobe <= 1'b0;
			last <= 1'b0;
			status <= 1'b0;
			vertex <= '0;
			reachable <= 1'b0;
			has_parent <= 1'b0;
			if (state_q == ST_EDGE_B || state_q == ST_ERR) begin
				strobe <= 1'b1;
				last <= 1'b1;
				status <= (state_q == ST_ERR);
			end else if (state_q == ST_EMIT) begin
				strobe <= 1'b1;
				last <= (i_q == n - CB'(1));
				vertex <= 6'(iv);
				reachable <= reach_q[iv];
				has_parent <= hasp_q[iv];
			end
		end
	end

	assign distance = reachable ? vrd_dist : '0;
	assign parent_vertex = has_parent ? 6'(vrd[VW-1:DIST_BITS]) : '0;
endmodule

// ===== design/spme_checker.sv =====
// Port-level checker for the shortest-path matrix engine, bound to the top.
module spme_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic last,
	input logic status
);
	// a result only appears while the block is busy or just finishing
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("result without work");
	// an error result is always the last word
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status) |-> last) else $error("error not last");
	// last drops busy
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy) else $error("busy after last");
	// accepting a word raises busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("no busy after start");
endmodule

bind shortest_path_matrix_engine_top spme_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.strobe(strobe), .last(last), .status(status)
);
